### rtl/rme_pkg.sv
// Package for rotation_matrix_to_euler: CORDIC angle table and shared types.
// No dependencies.
package rme_pkg;

  localparam int AngW = 34;

  typedef logic signed [AngW-1:0] ang_t;

  function automatic ang_t atan_val(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return ang_t'({2'b00, v});
  endfunction

  localparam logic signed [AngW-1:0] HalfTurn = 34'sd2147483648;
  localparam logic signed [31:0] PiQ29 = 32'sd1686629713;
  localparam int PiQ13 = 25736;
  localparam int HalfPiQ13 = 12868;

endpackage

### rtl/rme_sqrt_cell.sv
// One step of the pipelined integer square root (one result bit per cell).
// No dependencies.
module rme_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] rem_in,
  input  logic [15:0] root_in,
  output logic [31:0] rem_out,
  output logic [15:0] root_out
);
  // keep the next root bit when the square of the candidate still fits
  logic [33:0] trial;
  logic [33:0] rem_hi;
  logic [15:0] cand;

  always_comb begin
    cand   = root_in | (16'd1 << (15 - Step));
    trial  = 34'(cand) * 34'(cand);
    rem_hi = {2'b00, rem_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_in;
      root_out <= (trial <= rem_hi) ? cand : root_in;
    end
  end
endmodule

### rtl/rme_cordic_cell.sv
// One CORDIC vectoring micro-rotation; a row of these forms the atan2 chain.
// Depends on rme_pkg.
module rme_cordic_cell #(
  parameter int Step = 0,
  parameter int W = 20
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   x_in,
  input  logic signed [W-1:0]   y_in,
  input  rme_pkg::ang_t         z_in,
  output logic signed [W-1:0]   x_out,
  output logic signed [W-1:0]   y_out,
  output rme_pkg::ang_t         z_out
);
  import rme_pkg::*;
  logic signed [W-1:0] dx, dy;

  always_comb begin
    dx = y_in >>> Step;
    dy = x_in >>> Step;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in < 0) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - atan_val(Step);
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + atan_val(Step);
      end
    end
  end
endmodule

### rtl/rme_atan2.sv
// Pipelined atan2: pre-rotation, a chain of CORDIC cells, scale and clamp.
// Depends on rme_pkg and rme_cordic_cell.
module rme_atan2 #(
  parameter int Stages = 16,
  parameter int FracBits = 14,
  parameter int Lim = 25736
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] y0,
  input  logic signed [16:0] x0,
  output logic signed [15:0] ang
);
  import rme_pkg::*;
  localparam int N = (Stages > 30) ? 30 : Stages;
  localparam int W = FracBits + 6;
  localparam int Sh = FracBits - 14;

  logic signed [W-1:0] xs [N+1];
  logic signed [W-1:0] ys [N+1];
  ang_t zs [N+1];
  logic zero_pipe [N+1];
  logic signed [W-1:0] xw, yw;
  logic signed [65:0] prod;
  logic signed [18:0] res;
  logic signed [18:0] res_q;
  logic zero_q;

  always_comb begin
    if (Sh >= 0) begin
      xw = W'(x0) <<< ((Sh >= 0) ? Sh : 0);
      yw = W'(y0) <<< ((Sh >= 0) ? Sh : 0);
    end else begin
      xw = W'(x0 >>> ((Sh < 0) ? -Sh : 0));
      yw = W'(y0 >>> ((Sh < 0) ? -Sh : 0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_pipe[0] <= (x0 == 0) && (y0 == 0);
      if (xw < 0) begin
        xs[0] <= -xw;
        ys[0] <= -yw;
        zs[0] <= (yw >= 0) ? HalfTurn : -HalfTurn;
      end else begin
        xs[0] <= xw;
        ys[0] <= yw;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    rme_cordic_cell #(.Step(i), .W(W)) u_cell (
      .clk(clk), .en(en), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
      .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1]));
    always_ff @(posedge clk) begin
      if (en) zero_pipe[i+1] <= zero_pipe[i];
    end
  end

  // scale binary angle to Q3.13: z*pi(Q29)/2^47, round half up
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= 66'(zs[N]) * 66'(PiQ29) + (66'sd1 <<< 46);
      zero_q <= zero_pipe[N];
    end
  end

  assign res = 19'(prod >>> 47);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_q) res_q <= '0;
      else if (res > 19'(Lim)) res_q <= 19'(Lim);
      else if (res < -19'(Lim)) res_q <= -19'(Lim);
      else res_q <= res;
    end
  end

  assign ang = res_q[15:0];
endmodule

### rtl/rotation_matrix_to_euler.sv
// Top level of the rotation-matrix to ZYX Euler angle converter.
// Depends on rme_pkg, rme_sqrt_cell and rme_atan2.
//
// Takes one matrix per cycle and returns one angle set per cycle while the master
// side is not stalling. Its stages, in order: one input register stage that forms
// m00^2 + m10^2, 16 square-root cells that each settle one bit of sy, the CORDIC
// pre-rotation, CORDIC_STAGES micro-rotation cells (at most 30), a scale multiply
// and a clamp register.
// Every stage shares one clock enable that is high while the last stage is
// empty or the master side takes its result, so a stall on the master side
// holds every stage and drops s_axis_tready in the same cycle; bubbles inside
// the pipeline are not squeezed out while stalled. The clamp register is the
// output register. Three atan2 chains run in parallel; the singular flag picks
// the pitch operands before they enter the chain and zeroes yaw at the end.
// The threshold is sampled when an item leaves the square root, so write it
// only while no transfer is in flight.
module rotation_matrix_to_euler #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // m00, m10, m11, m12, m20, m21, m22
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pitch, roll, yaw, 1 pad bit
  output logic        m_axis_tuser    // singular
);
  import rme_pkg::*;
  localparam int N = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;
  localparam int Lat = 16 + 1 + N + 3;

  logic [14:0] threshold;
  logic        adv;
  logic        in_xfer;
  logic [Lat-1:0] vld;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) threshold <= 15'd1;
    else if (cfg_valid) threshold <= cfg_data;
  end

  // Advance every stage while the last one is empty or its result leaves.
  assign adv = !vld[Lat-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // sqrt chain with delayed matrix entries
  logic signed [15:0] m [7];
  for (genvar k = 0; k < 7; k++) begin : g_unpack
    assign m[k] = s_axis_tdata[16*k +: 16];
  end

  logic [31:0] rem [17];
  logic [15:0] root [17];
  logic [111:0] dly [17];
  logic signed [31:0] a00, a10;
  assign a00 = 32'(m[0]);
  assign a10 = 32'(m[1]);
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= a00 * a00 + a10 * a10;
      root[0] <= '0;
      dly[0]  <= s_axis_tdata;
    end
  end
  for (genvar s = 0; s < 16; s++) begin : g_sqrt
    rme_sqrt_cell #(.Step(s)) u_sq (
      .clk(clk), .en(adv), .rem_in(rem[s]), .root_in(root[s]),
      .rem_out(rem[s+1]), .root_out(root[s+1]));
    always_ff @(posedge clk) begin
      if (adv) dly[s+1] <= dly[s];
    end
  end

  logic signed [15:0] d [7];
  for (genvar k = 0; k < 7; k++) begin : g_d
    assign d[k] = dly[16][16*k +: 16];
  end
  logic sing;
  assign sing = {1'b0, root[16]} < {2'b00, threshold};

  logic signed [16:0] py, px;
  assign py = sing ? -17'(d[3]) : 17'(d[5]);
  assign px = sing ? 17'(d[2]) : 17'(d[6]);

  logic signed [15:0] pitch, roll, yaw;
  rme_atan2 #(.Stages(CORDIC_STAGES), .FracBits(FRAC_BITS), .Lim(PiQ13)) u_pitch (
    .clk(clk), .en(adv), .y0(py), .x0(px), .ang(pitch));
  rme_atan2 #(.Stages(CORDIC_STAGES), .FracBits(FRAC_BITS), .Lim(HalfPiQ13)) u_roll (
    .clk(clk), .en(adv), .y0(-17'(d[4])), .x0({1'b0, root[16]}), .ang(roll));
  rme_atan2 #(.Stages(CORDIC_STAGES), .FracBits(FRAC_BITS), .Lim(PiQ13)) u_yaw (
    .clk(clk), .en(adv), .y0(17'(d[1])), .x0(17'(d[0])), .ang(yaw));

  // carry the singular flag alongside the three chains
  logic sp [N+3];
  always_ff @(posedge clk) begin
    if (adv) sp[0] <= sing;
  end
  for (genvar j = 0; j < N + 2; j++) begin : g_sp
    always_ff @(posedge clk) begin
      if (adv) sp[j+1] <= sp[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Lat-2:0], in_xfer};
  end

  // Drop yaw when the gimbal-lock branch was taken.
  logic [15:0] yaw_out;
  assign yaw_out = sp[N+2] ? 16'd0 : yaw;
  assign m_axis_tvalid = vld[Lat-1];
  assign m_axis_tdata = {1'b0, yaw_out, roll[14:0], pitch};
  assign m_axis_tuser = sp[N+2];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))) else $error("result changed while stalled");
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready) else $error("input not held");
  a_sing_yaw: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[46:31] == 16'd0)
    else $error("yaw not zero when singular");
  a_thr: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> threshold == $past(cfg_data)) else $error("cfg lost");
endmodule
